### rtl/plc_pkg.sv
// Shared types and constants for the positional list store.
// No dependencies; imported by plc_cell, positional_list_store_unit and the testbench.
package plc_pkg;

    localparam int PLC_CAPACITY   = 16;
    localparam int PLC_DATA_WIDTH = 32;

    typedef enum logic [2:0] {
        KIND_INS_BEFORE = 3'd0,
        KIND_INS_AFTER  = 3'd1,
        KIND_INS_FRONT  = 3'd2,
        KIND_INS_END    = 3'd3,
        KIND_READ       = 3'd4,
        KIND_DELETE     = 3'd5
    } plc_kind_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } plc_status_t;

    // Broadcast to every cell of the chain for one cycle
    typedef struct packed {
        logic insert;
        logic remove;
    } plc_cmd_t;

endpackage

### rtl/positional_list_store_unit.sv
// Top level of the positional list store: request decode, count, result
// register and the chain of plc_cell storage cells. Depends on plc_pkg, plc_cell.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  request | in_valid / in_ready  | kind, position, value
//  result  | out_valid/ out_ready | status, read_value, entry_count
//
// One item per cycle: each request is decoded and applied to the whole cell
// chain in the cycle it is accepted; its result sits in the output register
// the next cycle. A stalled result only holds off a new item until it is taken.
// rst_n clears the count and the result valid; cell contents are not reset.
module positional_list_store_unit #(
    parameter int CAPACITY   = plc_pkg::PLC_CAPACITY,
    parameter int DATA_WIDTH = plc_pkg::PLC_DATA_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic [4:0]         position,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] read_value,
    output logic [4:0]         entry_count
);
    import plc_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > 6) ? CNT_W : 6;
    // position is five bits, so reads reach at most the first 32 cells
    localparam int RD_N0  = (CAPACITY < 32) ? CAPACITY : 32;
    localparam int RD_W   = (RD_N0 > 1) ? $clog2(RD_N0) : 1;
    localparam int RD_N   = 1 << RD_W;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  out_valid_reg;
    logic [1:0]            status_reg;
    logic [31:0]           read_value_reg;
    logic [4:0]            entry_count_reg;

    logic                  accept;
    plc_cmd_t              cmd;
    plc_cmd_t              cmd_eff;
    logic [CMP_W-1:0]      at;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  pos_ok;
    logic                  full;
    plc_status_t           status_n;
    logic [31:0]           rd_n;
    logic [DATA_WIDTH-1:0] ins_data;
    logic [63:0]           value_wide;
    logic [63:0]           rd_wide;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_tab    [RD_N];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign pos_ext    = CMP_W'(position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign pos_ok     = pos_ext < cnt_ext;
    assign full       = cnt_ext >= CMP_W'(CAPACITY);
    assign value_wide = 64'($unsigned(value));
    assign ins_data   = value_wide[DATA_WIDTH-1:0];
    assign rd_wide    = 64'(rd_tab[position[RD_W-1:0]]);

    always_comb
    begin
        status_n   = STATUS_DONE;
        rd_n       = '0;
        cmd        = '0;
        at         = '0;
        count_next = count_reg;
        unique case (kind) inside
            KIND_INS_BEFORE, KIND_INS_AFTER:
            begin
                if (!pos_ok)
                    status_n = STATUS_RANGE;
                else if (full)
                    status_n = STATUS_FULL;
                else
                begin
                    cmd.insert = 1'b1;
                    at         = (kind == KIND_INS_BEFORE) ? pos_ext : pos_ext + CMP_W'(1);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_INS_FRONT, KIND_INS_END:
            begin
                if (full)
                    status_n = STATUS_FULL;
                else
                begin
                    cmd.insert = 1'b1;
                    at         = (kind == KIND_INS_FRONT) ? '0 : cnt_ext;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_READ:
            begin
                if (!pos_ok)
                    status_n = STATUS_RANGE;
                else
                    rd_n = rd_wide[31:0];
            end
            KIND_DELETE:
            begin
                if (!pos_ok)
                    status_n = STATUS_RANGE;
                else
                begin
                    cmd.remove = 1'b1;
                    at         = pos_ext;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
                status_n = STATUS_RANGE;
        endcase
    end

    assign cmd_eff = accept ? cmd : '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_d;
            logic [DATA_WIDTH-1:0] right_d;
            if (g == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_left
                assign left_d = cell_data[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_right
                assign right_d = cell_data[g+1];
            end

            plc_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CMP_W      (CMP_W),
                .INDEX      (g)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd_eff),
                .at         (at),
                .ins_data   (ins_data),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[g])
            );
        end

        for (g = 0; g < RD_N; g++)
        begin : g_rd
            if (g < CAPACITY)
            begin : g_tap
                assign rd_tab[g] = cell_data[g];
            end
            else
            begin : g_pad
                assign rd_tab[g] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_n;
            read_value_reg  <= rd_n;
            entry_count_reg <= 5'(count_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;

endmodule

### rtl/plc_cell.sv
// One storage cell of the list chain: holds one entry and shifts toward
// either neighbor on insert/delete. Depends on plc_pkg.
module plc_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CMP_W      = 6,
    parameter int INDEX      = 0
) (
    input  logic                    clk,
    input  plc_pkg::plc_cmd_t       cmd,
    input  logic [CMP_W-1:0]        at,
    input  logic [DATA_WIDTH-1:0]   ins_data,
    input  logic [DATA_WIDTH-1:0]   left_data,
    input  logic [DATA_WIDTH-1:0]   right_data,
    output logic [DATA_WIDTH-1:0]   data
);
    import plc_pkg::*;

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.insert)
        begin
            if (MY_IDX > at)
                data_next = left_data;
            else if (MY_IDX == at)
                data_next = ins_data;
        end
        else if (cmd.remove)
        begin
            if (MY_IDX >= at)
                data_next = right_data;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### verif/tb_positional_list_store_unit.sv
// Testbench for positional_list_store_unit: directed list edge cases, then random
// insert/read/delete traffic checked against a queue-based list predictor.
// Depends on plc_pkg and the RTL of positional_list_store_unit.
`timescale 1ns / 100ps

module tb_positional_list_store_unit;
    import plc_pkg::*;

    // Kinds with no meaning; the block reports them as out of range
    localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
    localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        plc_status_t status;
        logic [31:0] read_value;
        logic [4:0]  entry_count;
    } list_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         kind = KIND_READ;
    logic [4:0]         position = '0;
    logic signed [31:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;

    logic [31:0]  list_model[$];
    list_result_t pending_results[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    bit           rx_stall_en = 1'b0;
    int           rx_left = 0;

    positional_list_store_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("positional_list_store_unit verification failed");
            $finish;
        end
    end

    // Receiver: ready/stall runs of random length while stalling is enabled
    always @(posedge clk)
    begin
        if (!rx_stall_en)
            out_ready <= 1'b1;
        else if (rx_left != 0)
            rx_left <= rx_left - 1;
        else
        begin
            out_ready <= !out_ready;
            rx_left   <= out_ready ? $urandom_range(0, 7) : $urandom_range(0, 4);
        end
    end

    // Applies one request to the list model and returns the result it gives
    function automatic list_result_t predict_list_op(input logic [2:0] k,
                                                     input logic [4:0] p,
                                                     input logic [31:0] v);
        list_result_t r;
        bit pos_ok;
        bit full;
        r.status     = STATUS_DONE;
        r.read_value = '0;
        pos_ok = int'(p) < list_model.size();
        full   = list_model.size() >= PLC_CAPACITY;
        case (k) inside
            KIND_INS_BEFORE, KIND_INS_AFTER:
                if (!pos_ok)
                    r.status = STATUS_RANGE;
                else if (full)
                    r.status = STATUS_FULL;
                else
                    list_model.insert((k == KIND_INS_BEFORE) ? int'(p) : int'(p) + 1, v);
            KIND_INS_FRONT, KIND_INS_END:
                if (full)
                    r.status = STATUS_FULL;
                else if (k == KIND_INS_FRONT)
                    list_model.push_front(v);
                else
                    list_model.push_back(v);
            KIND_READ:
                if (!pos_ok)
                    r.status = STATUS_RANGE;
                else
                    r.read_value = list_model[p];
            KIND_DELETE:
                if (!pos_ok)
                    r.status = STATUS_RANGE;
                else
                    list_model.delete(p);
            default:
                r.status = STATUS_RANGE;
        endcase
        r.entry_count = 5'(list_model.size());
        return r;
    endfunction

    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: status %0d count %0d",
                       status, entry_count);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, status);
                    fail_count++;
                end
                if (read_value !== exp_r.read_value)
                begin
                    $error("read_value expected %h actual %h", exp_r.read_value, read_value);
                    fail_count++;
                end
                if (entry_count !== exp_r.entry_count)
                begin
                    $error("entry_count expected %0d actual %0d",
                           exp_r.entry_count, entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge where the item is accepted
    task automatic send_item(input logic [2:0] k, input logic [4:0] p, input logic [31:0] v);
        in_valid <= 1'b1;
        kind     <= k;
        position <= p;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_list_op(k, p, v));
    endtask

    task automatic idle_for(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_list();
        send_item(KIND_READ, 5'd0, 32'h1234_5678);
        send_item(KIND_DELETE, 5'd0, 32'h0);
        send_item(KIND_INS_BEFORE, 5'd0, 32'hDEAD_BEEF);
        send_item(KIND_INS_AFTER, 5'd31, 32'hFFFF_FFFF);
        send_item(KIND_UNUSED_6, 5'd0, 32'h0);
        send_item(KIND_UNUSED_7, 5'd31, 32'h8000_0000);
        wait_drained();
    endtask

    task automatic test_fill_to_capacity();
        send_item(KIND_INS_FRONT, 5'd0, 32'h7FFF_FFFF);
        send_item(KIND_INS_END, 5'd31, 32'h8000_0000);
        send_item(KIND_INS_BEFORE, 5'd0, 32'hFFFF_FFFF);
        send_item(KIND_INS_AFTER, 5'd2, 32'h0000_0000);
        for (int i = 0; i < PLC_CAPACITY - 4; i++)
        begin
            case (i % 4)
                0: send_item(KIND_INS_FRONT, 5'd0, $urandom);
                1: send_item(KIND_INS_END, 5'd0, $urandom);
                2: send_item(KIND_INS_BEFORE, 5'(list_model.size() - 1), $urandom);
                default: send_item(KIND_INS_AFTER, 5'(list_model.size() - 1), $urandom);
            endcase
        end
        wait_drained();
    endtask

    task automatic test_full_list();
        send_item(KIND_INS_FRONT, 5'd0, 32'h5555_5555);
        send_item(KIND_INS_AFTER, 5'd15, 32'hAAAA_AAAA);
        // bad position wins over full
        send_item(KIND_INS_BEFORE, 5'd16, 32'h1);
        send_item(KIND_READ, 5'd15, 32'h0);
        send_item(KIND_DELETE, 5'd0, 32'h0);
        wait_drained();
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_traffic();
        int ins_pct = 50;
        bit gaps_on = 1'b0;
        int burst_left = 1;
        int roll;
        logic [2:0] k;
        logic [4:0] p;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // new phase: shift the insert/remove balance to sweep empty and full, and redraw gaps and stalls
            if (n % 64 == 0)
            begin
                ins_pct     = $urandom_range(10, 90);
                gaps_on     = $urandom_range(0, 3) != 0;
                rx_stall_en = $urandom_range(0, 3) != 0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                k = $urandom_range(0, 1) ? KIND_UNUSED_6 : KIND_UNUSED_7;
            else if ($urandom_range(0, 99) < ins_pct)
                k = 3'($urandom_range(KIND_INS_BEFORE, KIND_INS_END));
            else
                k = $urandom_range(0, 1) ? KIND_READ : KIND_DELETE;
            if (list_model.size() > 0 && $urandom_range(0, 3) != 0)
                p = 5'($urandom_range(0, list_model.size() - 1));
            else
                p = 5'($urandom_range(0, 31));
            send_item(k, p, pick_value());
            if ($urandom_range(0, 99) == 0)
                wait_drained();
            burst_left--;
            if (burst_left <= 0)
            begin
                if (gaps_on)
                    idle_for($urandom_range(1, 6));
                burst_left = $urandom_range(1, 20);
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        rx_stall_en = 1'b1;
        test_fill_to_capacity();
        rx_stall_en = 1'b0;
        test_full_list();
        test_random_traffic();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("positional_list_store_unit verification clean");
        else
            $display("positional_list_store_unit verification failed");
        $finish;
    end

endmodule
